/* hdl/opr_pkg.sv */
package opr_pkg;

    // Frame size limit and ratio fixed-point format.
    localparam int MAX_FRAME_PIXELS = 65536;
    localparam int RATIO_FRAC_BITS  = 10;

    localparam int CHAN_W   = 8;
    localparam int CHAN_MAX = 255;
    localparam int RATIO_W  = CHAN_W + RATIO_FRAC_BITS;
    localparam int CNT_W    = $clog2(MAX_FRAME_PIXELS + 1);
    localparam int RSUM_W   = RATIO_W + CNT_W - 1;
    localparam int BSUM_W   = CHAN_W + CNT_W - 1;

    // Shared divider sizing: the widest dividend is the ratio sum, the widest
    // divisor is either the pixel count or a green plus blue sum.
    localparam int DIV_W  = RSUM_W;
    localparam int DEN_W  = (CNT_W > CHAN_W + 1) ? CNT_W : CHAN_W + 1;
    localparam int STEP_W = $clog2(DIV_W + 1);

    localparam int RATIO_MUL = 50;
    localparam int MUL_W     = 6;
    localparam int PROD_W    = RATIO_W + MUL_W;

    typedef struct packed {
        logic              mode;
        logic [CHAN_W-1:0] pix_red;
        logic [CHAN_W-1:0] pix_green;
        logic [CHAN_W-1:0] pix_blue;
        logic              frame_end;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] gray_level;
        logic              mask_on;
        logic              end_out;
    } out_item_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  num;
        logic [DEN_W-1:0]  den;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PIX_DIV,
        ST_FEND,
        ST_AVG_RATIO,
        ST_AVG_BLUE,
        ST_GRAY,
        ST_OUT
    } state_t;

endpackage

/* hdl/opr_if.sv */
interface opr_in_if;
    logic               valid;
    logic               ready;
    opr_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface opr_out_if;
    logic               valid;
    logic               ready;
    opr_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/orange_pixel_ratio_filter_top.sv */
// Orange pixel ratio filter.
//
// Requests arrive on in_chan and results leave on out_chan, both valid/ready
// channels; one request gives exactly one result, in order. A frame is sent
// twice. In pass 0 (mode low) each BGR pixel comes back as an orange-emphasized
// pixel, and its red/(green+blue) ratio and blue are summed; the request that
// carries frame_end turns the averages into the thresholds for pass 1. In
// pass 1 (mode high) the caller sends back the filtered pixels and gets a
// gray level and a mask bit.
//
// Requests are processed one at a time on a single restoring divider, one
// quotient bit per cycle. A pixel with a ratio division passes through
// evaluation, the division (18 divider steps), grading in pass 1, and output;
// one without a division goes from evaluation to grading or output.
// A pass-0 frame end adds both averages (34 + 24 steps) unless no pixel was counted.
// in_chan.ready is high only while the sequencer is idle. A finished result
// waits in the output register while the next request is already taken; if
// the receiver stalls longer, the sequencer holds before writing that register.
// Reset clears the sums, the count and both thresholds to zero, so pass 1
// before the first pass-0 frame end rejects every pixel.
module orange_pixel_ratio_filter_top (
    input  logic     clk,
    input  logic     rst_n,
    opr_in_if.sink   in_chan,
    opr_out_if.source out_chan
);

    localparam int FW = opr_pkg::CHAN_W + 4;

    opr_pkg::state_t    state_reg;
    opr_pkg::state_t    state_next;

    opr_pkg::in_item_t  item_reg;
    logic [opr_pkg::CHAN_W-1:0]  fr_reg;
    logic [opr_pkg::CHAN_W-1:0]  fg_reg;
    logic [opr_pkg::CHAN_W-1:0]  fb_reg;
    logic [opr_pkg::RATIO_W-1:0] ratio_reg;
    logic [opr_pkg::CHAN_W-1:0]  gray_reg;
    logic                        mask_reg;

    logic [opr_pkg::RSUM_W-1:0]  ratio_sum_reg;
    logic [opr_pkg::BSUM_W-1:0]  blue_sum_reg;
    logic [opr_pkg::CNT_W-1:0]   counted_reg;
    logic [opr_pkg::RATIO_W-1:0] ratio_limit_reg;
    logic [opr_pkg::CHAN_W-1:0]  blue_limit_reg;

    logic                        out_valid_reg;
    opr_pkg::out_item_t          out_data_reg;

    opr_pkg::div_req_t  div_req;
    opr_pkg::div_rsp_t  div_rsp;

    // Pass-0 color filter, evaluated on the held request.
    logic [FW-1:0]               r12;
    logic [FW-1:0]               g12;
    logic [FW-1:0]               b12;
    logic                        hue_ok;
    logic [FW-1:0]               t_r;
    logic [FW-1:0]               t_g;
    logic [opr_pkg::CHAN_W-1:0]  c_r;
    logic [opr_pkg::CHAN_W-1:0]  c_g;
    logic [opr_pkg::CHAN_W-1:0]  c_b;
    logic                        too_blue;
    logic [opr_pkg::CHAN_W:0]    den_f;
    logic                        black;
    logic [opr_pkg::CHAN_W-1:0]  f_r;
    logic [opr_pkg::CHAN_W-1:0]  f_g;
    logic [opr_pkg::CHAN_W-1:0]  f_b;
    logic                        count_it;

    // Ratio numerator and denominator for either pass.
    logic [opr_pkg::CHAN_W-1:0]  num_red;
    logic [opr_pkg::CHAN_W:0]    den_pix;
    logic                        pix_div;

    // Pass-1 grading.
    logic [opr_pkg::PROD_W-1:0]  gray_prod;
    logic [opr_pkg::PROD_W-opr_pkg::RATIO_FRAC_BITS-1:0] gray_scaled;
    logic                        pass_ok;

    logic                        out_load;
    logic                        counted_zero;

    // Saturates a signed difference to the channel range.
    function automatic logic [opr_pkg::CHAN_W-1:0] clamp_chan(input logic [FW-1:0] v);
        logic [opr_pkg::CHAN_W-1:0] res;
        if (v[FW-1])
        begin
            res = '0;
        end
        else if (v[FW-2:opr_pkg::CHAN_W] != '0)
        begin
            res = opr_pkg::CHAN_W'(opr_pkg::CHAN_MAX);
        end
        else
        begin
            res = v[opr_pkg::CHAN_W-1:0];
        end
        return res;
    endfunction

    opr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        r12      = FW'(item_reg.pix_red);
        g12      = FW'(item_reg.pix_green);
        b12      = FW'(item_reg.pix_blue);
        hue_ok   = ((b12 * FW'(10)) < (r12 * FW'(9))) && ((b12 * FW'(10)) < (g12 * FW'(9)));
        t_r      = (r12 << 2) - (g12 << 1) - b12;
        t_g      = (g12 * FW'(3)) - (b12 * FW'(3));
        c_r      = hue_ok ? clamp_chan(t_r) : '0;
        c_g      = hue_ok ? clamp_chan(t_g) : '0;
        c_b      = hue_ok ? item_reg.pix_blue : '0;
        too_blue = ((FW'(c_b) * FW'(3)) + (FW'(c_g) << 1)) > (FW'(c_r) << 2);
        den_f    = {1'b0, c_g} + {1'b0, c_b};
        // A pixel with no green or blue left has no defined ratio and goes black.
        black    = too_blue || (den_f == '0);
        f_r      = black ? '0 : c_r;
        f_g      = black ? '0 : c_g;
        f_b      = black ? '0 : c_b;
        count_it = !black && (counted_reg < opr_pkg::CNT_W'(opr_pkg::MAX_FRAME_PIXELS));

        num_red  = item_reg.mode ? item_reg.pix_red : f_r;
        den_pix  = item_reg.mode ? ({1'b0, item_reg.pix_green} + {1'b0, item_reg.pix_blue})
                                 : den_f;
        pix_div  = item_reg.mode ? (den_pix != '0) : count_it;

        counted_zero = (counted_reg == '0);
    end

    always_comb
    begin
        gray_prod   = opr_pkg::PROD_W'(ratio_reg) * opr_pkg::PROD_W'(opr_pkg::RATIO_MUL);
        gray_scaled = gray_prod[opr_pkg::PROD_W-1:opr_pkg::RATIO_FRAC_BITS];
        pass_ok     = (item_reg.pix_blue < blue_limit_reg) && (ratio_reg > ratio_limit_reg);
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            opr_pkg::ST_IDLE:
            begin
                if (in_chan.valid)
                begin
                    state_next = opr_pkg::ST_EVAL;
                end
            end
            opr_pkg::ST_EVAL:
            begin
                if (pix_div)
                begin
                    state_next = opr_pkg::ST_PIX_DIV;
                end
                else if (item_reg.mode)
                begin
                    state_next = opr_pkg::ST_GRAY;
                end
                else if (item_reg.frame_end)
                begin
                    state_next = opr_pkg::ST_FEND;
                end
                else
                begin
                    state_next = opr_pkg::ST_OUT;
                end
            end
            opr_pkg::ST_PIX_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (item_reg.mode)
                    begin
                        state_next = opr_pkg::ST_GRAY;
                    end
                    else if (item_reg.frame_end)
                    begin
                        state_next = opr_pkg::ST_FEND;
                    end
                    else
                    begin
                        state_next = opr_pkg::ST_OUT;
                    end
                end
            end
            opr_pkg::ST_FEND:
            begin
                state_next = counted_zero ? opr_pkg::ST_OUT : opr_pkg::ST_AVG_RATIO;
            end
            opr_pkg::ST_AVG_RATIO:
            begin
                if (div_rsp.done)
                begin
                    state_next = opr_pkg::ST_AVG_BLUE;
                end
            end
            opr_pkg::ST_AVG_BLUE:
            begin
                if (div_rsp.done)
                begin
                    state_next = opr_pkg::ST_OUT;
                end
            end
            opr_pkg::ST_GRAY:
            begin
                state_next = opr_pkg::ST_OUT;
            end
            opr_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = opr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = opr_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input handshake and divider requests.
    always_comb
    begin
        in_chan.ready = 1'b0;
        out_load      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = opr_pkg::DIV_W'(num_red) << (opr_pkg::DIV_W - opr_pkg::CHAN_W);
        div_req.den   = opr_pkg::DEN_W'(den_pix);
        div_req.steps = opr_pkg::STEP_W'(opr_pkg::RATIO_W);
        unique case (state_reg)
            opr_pkg::ST_IDLE:
            begin
                in_chan.ready = 1'b1;
            end
            opr_pkg::ST_EVAL:
            begin
                div_req.start = pix_div;
            end
            opr_pkg::ST_FEND:
            begin
                div_req.start = !counted_zero;
                div_req.num   = opr_pkg::DIV_W'(ratio_sum_reg);
                div_req.den   = opr_pkg::DEN_W'(counted_reg);
                div_req.steps = opr_pkg::STEP_W'(opr_pkg::RSUM_W);
            end
            opr_pkg::ST_AVG_RATIO:
            begin
                div_req.start = div_rsp.done;
                div_req.num   = opr_pkg::DIV_W'(blue_sum_reg) << (opr_pkg::DIV_W - opr_pkg::BSUM_W);
                div_req.den   = opr_pkg::DEN_W'(counted_reg);
                div_req.steps = opr_pkg::STEP_W'(opr_pkg::BSUM_W);
            end
            opr_pkg::ST_OUT:
            begin
                out_load = !out_valid_reg || out_chan.ready;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= opr_pkg::ST_IDLE;
            out_valid_reg   <= 1'b0;
            ratio_sum_reg   <= '0;
            blue_sum_reg    <= '0;
            counted_reg     <= '0;
            ratio_limit_reg <= '0;
            blue_limit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if ((state_reg == opr_pkg::ST_PIX_DIV) && div_rsp.done && !item_reg.mode)
            begin
                ratio_sum_reg <= ratio_sum_reg
                               + opr_pkg::RSUM_W'(div_rsp.quo[opr_pkg::RATIO_W-1:0]);
                blue_sum_reg  <= blue_sum_reg + opr_pkg::BSUM_W'(fb_reg);
                counted_reg   <= counted_reg + opr_pkg::CNT_W'(1);
            end

            if ((state_reg == opr_pkg::ST_FEND) && counted_zero)
            begin
                ratio_limit_reg <= '0;
                blue_limit_reg  <= '0;
                ratio_sum_reg   <= '0;
                blue_sum_reg    <= '0;
            end

            if ((state_reg == opr_pkg::ST_AVG_RATIO) && div_rsp.done)
            begin
                ratio_limit_reg <= div_rsp.quo[opr_pkg::RATIO_W-1:0];
            end

            if ((state_reg == opr_pkg::ST_AVG_BLUE) && div_rsp.done)
            begin
                blue_limit_reg <= div_rsp.quo[opr_pkg::CHAN_W-1:0];
                ratio_sum_reg  <= '0;
                blue_sum_reg   <= '0;
                counted_reg    <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_chan.valid && in_chan.ready)
        begin
            item_reg <= in_chan.data;
        end

        if (state_reg == opr_pkg::ST_EVAL)
        begin
            fr_reg    <= f_r;
            fg_reg    <= f_g;
            fb_reg    <= f_b;
            // With a zero denominator the ratio is the shifted red alone.
            ratio_reg <= {item_reg.pix_red, opr_pkg::RATIO_FRAC_BITS'(0)};
        end

        if ((state_reg == opr_pkg::ST_PIX_DIV) && div_rsp.done)
        begin
            ratio_reg <= div_rsp.quo[opr_pkg::RATIO_W-1:0];
        end

        if (state_reg == opr_pkg::ST_GRAY)
        begin
            mask_reg <= pass_ok;
            if (!pass_ok)
            begin
                gray_reg <= '0;
            end
            else if (gray_scaled > opr_pkg::CHAN_MAX)
            begin
                gray_reg <= opr_pkg::CHAN_W'(opr_pkg::CHAN_MAX);
            end
            else
            begin
                gray_reg <= gray_scaled[opr_pkg::CHAN_W-1:0];
            end
        end

        if (out_load)
        begin
            out_data_reg.end_out <= item_reg.frame_end;
            if (item_reg.mode)
            begin
                out_data_reg.out_red    <= '0;
                out_data_reg.out_green  <= '0;
                out_data_reg.out_blue   <= '0;
                out_data_reg.gray_level <= gray_reg;
                out_data_reg.mask_on    <= mask_reg;
            end
            else
            begin
                out_data_reg.out_red    <= fr_reg;
                out_data_reg.out_green  <= fg_reg;
                out_data_reg.out_blue   <= fb_reg;
                out_data_reg.gray_level <= '0;
                out_data_reg.mask_on    <= 1'b0;
            end
        end
    end

    assign out_chan.valid = out_valid_reg;
    assign out_chan.data  = out_data_reg;

endmodule

/* hdl/opr_div.sv */
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// left-aligned so that a run of N steps divides its top N bits; the quotient
// then sits in the low N bits of the shift register.
module opr_div (
    input  logic                clk,
    input  logic                rst_n,
    input  opr_pkg::div_req_t   req,
    output opr_pkg::div_rsp_t   rsp
);

    logic [opr_pkg::DIV_W-1:0]  sh_reg;
    logic [opr_pkg::DEN_W-1:0]  rem_reg;
    logic [opr_pkg::DEN_W-1:0]  den_reg;
    logic [opr_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [opr_pkg::DEN_W:0]    rem_sh;
    logic                       fits;
    logic [opr_pkg::DEN_W-1:0]  rem_next;

    always_comb
    begin
        rem_sh = {rem_reg, sh_reg[opr_pkg::DIV_W-1]};
        fits   = rem_sh >= {1'b0, den_reg};
        if (fits)
        begin
            rem_next = opr_pkg::DEN_W'(rem_sh - {1'b0, den_reg});
        end
        else
        begin
            rem_next = rem_sh[opr_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == opr_pkg::STEP_W'(1)) && !req.start;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - opr_pkg::STEP_W'(1);
                if (cnt_reg == opr_pkg::STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            sh_reg  <= req.num;
            rem_reg <= '0;
            den_reg <= req.den;
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[opr_pkg::DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = sh_reg;

endmodule
